// ===== rtl/rasmr_pkg.sv =====
`default_nettype none
package rasmr_pkg;
  localparam int unsigned OpW  = 16;
  localparam int unsigned NumW = 33;
  localparam int unsigned DenW = 32;
  localparam int unsigned MagW = 2 * OpW + 1;
  localparam int unsigned QDepth = 2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  typedef struct packed {
    logic [1:0]     op;
    logic [OpW-1:0] a_num;
    logic [OpW-1:0] a_den;
    logic [OpW-1:0] b_num;
    logic [OpW-1:0] b_den;
  } item_t;

  typedef struct packed {
    logic [NumW-1:0] res_num;
    logic [DenW-1:0] res_den;
  } result_t;
endpackage
`default_nettype wire

// ===== rtl/rasmr_front.sv =====
`default_nettype none
// input queue between the accepting side and the arithmetic unit
module rasmr_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire rasmr_pkg::item_t item_i,
  output logic                  valid_o,
  input  wire logic             take_i,
  output rasmr_pkg::item_t      item_o
);
  rasmr_pkg::item_t mem_q [rasmr_pkg::QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign full_o  = (cnt_q == 2'(rasmr_pkg::QDepth));
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rp_q];
  assign wr = push_i && !full_o;
  assign rd = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rasmr_back.sv =====
`default_nettype none
// products, then euclid gcd and, when the gcd exceeds one, two exact divides with one restoring divider
module rasmr_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  take_o,
  input  wire rasmr_pkg::item_t item_i,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output rasmr_pkg::result_t    res_o
);
  localparam int unsigned M = rasmr_pkg::MagW;
  localparam int unsigned CW = $clog2(M + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P1   = 4'd1;
  localparam logic [3:0] S_P2   = 4'd2;
  localparam logic [3:0] S_P3   = 4'd3;
  localparam logic [3:0] S_GST  = 4'd4;
  localparam logic [3:0] S_GDIV = 4'd5;
  localparam logic [3:0] S_NST  = 4'd6;
  localparam logic [3:0] S_NDIV = 4'd7;
  localparam logic [3:0] S_DDIV = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] st_q;
  rasmr_pkg::item_t it_q;
  logic signed [2*rasmr_pkg::OpW:0] p_q;
  logic signed [M-1:0] num_q, den_q;
  logic [M-1:0] sml_q;
  // divider: dividend shifted into quotient, remainder register
  logic [M-1:0] dq_q, rem_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic out_v_q;
  rasmr_pkg::result_t out_q;
  logic [M:0] trial;
  logic [M:0] rsh;
  logic signed [rasmr_pkg::OpW:0] bn_x;
  logic [M-1:0] nmag, dmag;
  logic neg_n, neg_d;

  assign nmag = num_q[M-1] ? M'(-num_q) : M'(num_q);
  assign dmag = den_q[M-1] ? M'(-den_q) : M'(den_q);
  assign rsh   = {rem_q, dq_q[M-1]};
  assign trial = rsh - {1'b0, dvs_q};
  assign bn_x  = it_q.op == rasmr_pkg::OP_SUB ? -$signed({it_q.b_num[rasmr_pkg::OpW-1],
                 it_q.b_num}) : $signed({it_q.b_num[rasmr_pkg::OpW-1], it_q.b_num});
  assign take_o  = (st_q == S_IDLE) && valid_i;
  assign empty_o = !out_v_q;
  assign res_o   = out_q;
  assign neg_n = num_q[M-1];
  assign neg_d = den_q[M-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      out_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (pop_i && out_v_q) out_v_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (valid_i) st_q <= S_P1;
        S_P1:   st_q <= S_P2;
        S_P2:   st_q <= S_P3;
        S_P3:   st_q <= S_GST;
        S_GST: begin
          if (nmag == '0 || dmag == '0) st_q <= S_NST;
          else st_q <= S_GDIV;
          cnt_q <= CW'(M);
        end
        S_GDIV: begin
          if (cnt_q == '0) begin
            if (rem_q == '0) st_q <= S_NST;
            cnt_q <= CW'(M);
          end else begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
        S_NST: begin
          if (sml_q > M'(1)) st_q <= S_NDIV;
          else st_q <= S_OUT;
          cnt_q <= CW'(M);
        end
        S_NDIV: begin
          if (cnt_q == '0) begin
            st_q <= S_DDIV;
            cnt_q <= CW'(M);
          end else cnt_q <= cnt_q - CW'(1);
        end
        S_DDIV: begin
          if (cnt_q == '0) st_q <= S_OUT;
          else cnt_q <= cnt_q - CW'(1);
        end
        S_OUT: if (!out_v_q) begin
          out_v_q <= 1'b1;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: if (valid_i) it_q <= item_i;
      S_P1: begin
        // numerator first product
        if (it_q.op[1]) p_q <= (2*rasmr_pkg::OpW+1)'($signed(it_q.a_num) *
                                                     $signed(it_q.b_num));
        else p_q <= (2*rasmr_pkg::OpW+1)'($signed(it_q.a_num) * $signed(it_q.b_den));
      end
      S_P2: begin
        num_q <= M'(p_q);
        if (!it_q.op[1]) p_q <= (2*rasmr_pkg::OpW+1)'(bn_x * $signed(it_q.a_den));
        else p_q <= '0;
      end
      S_P3: begin
        num_q <= num_q + M'(p_q);
        den_q <= M'($signed(it_q.a_den) * $signed(it_q.b_den));
      end
      S_GST: begin
        if (nmag == '0 || dmag == '0) begin
          sml_q <= nmag | dmag;
        end else begin
          sml_q <= (nmag > dmag) ? dmag : nmag;
          dq_q  <= (nmag > dmag) ? nmag : dmag;
          dvs_q <= (nmag > dmag) ? dmag : nmag;
          rem_q <= '0;
        end
      end
      S_GDIV: begin
        if (cnt_q != '0) begin
          dq_q <= {dq_q[M-2:0], !trial[M]};
          rem_q <= trial[M] ? rsh[M-1:0] : trial[M-1:0];
        end else if (rem_q != '0) begin
          // next euclid round: (small, rem)
          dq_q  <= sml_q;
          dvs_q <= rem_q;
          sml_q <= rem_q;
          rem_q <= '0;
        end
      end
      S_NST: begin
        dq_q  <= nmag;
        dvs_q <= sml_q;
        rem_q <= '0;
      end
      S_NDIV: begin
        if (cnt_q != '0) begin
          dq_q <= {dq_q[M-2:0], !trial[M]};
          rem_q <= trial[M] ? rsh[M-1:0] : trial[M-1:0];
        end else begin
          num_q <= neg_n ? -$signed(dq_q) : $signed(dq_q);
          dq_q  <= dmag;
          rem_q <= '0;
        end
      end
      S_DDIV: begin
        if (cnt_q != '0) begin
          dq_q <= {dq_q[M-2:0], !trial[M]};
          rem_q <= trial[M] ? rsh[M-1:0] : trial[M-1:0];
        end else begin
          den_q <= neg_d ? -$signed(dq_q) : $signed(dq_q);
        end
      end
      S_OUT: begin
        // a word still waiting for pop keeps its value
        if (!out_v_q) begin
          out_q.res_num <= rasmr_pkg::NumW'(num_q);
          out_q.res_den <= rasmr_pkg::DenW'(den_q);
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/rational_add_sub_mul_reduce_core.sv =====
`default_nettype none
// channel  | valid/ready   | fields
// input    | push/full     | op_i a_num_i a_den_i b_num_i b_den_i
// result   | empty/pop     | res_num_o res_den_o
// an item passes accept, the product states P1 to P3 and gcd setup, then one
// restoring divider run per euclid step, and two more runs for the final divides
// when the gcd exceeds one; the euclid step count of the data sets how long
// an item takes
// a two-word input queue keeps accepting, until full, while the divider works
// a word waiting for pop holds the back end in its output state
// async active-low reset empties queue and result register
module rational_add_sub_mul_reduce_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [1:0]                  op_i,
  input  wire logic [rasmr_pkg::OpW-1:0]   a_num_i,
  input  wire logic [rasmr_pkg::OpW-1:0]   a_den_i,
  input  wire logic [rasmr_pkg::OpW-1:0]   b_num_i,
  input  wire logic [rasmr_pkg::OpW-1:0]   b_den_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [rasmr_pkg::NumW-1:0]       res_num_o,
  output logic [rasmr_pkg::DenW-1:0]       res_den_o
);
  rasmr_pkg::item_t in_w, q_w;
  rasmr_pkg::result_t res_w;
  logic q_v, q_take;

  assign in_w = '{op: op_i, a_num: a_num_i, a_den: a_den_i, b_num: b_num_i, b_den: b_den_i};

  rasmr_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_w),
    .valid_o(q_v), .take_i(q_take), .item_o(q_w)
  );

  rasmr_back u_back (
    .clk_i, .rst_ni, .valid_i(q_v), .take_o(q_take), .item_i(q_w),
    .empty_o(empty), .pop_i(pop), .res_o(res_w)
  );

  assign res_num_o = res_w.res_num;
  assign res_den_o = res_w.res_den;
endmodule
`default_nettype wire

// ===== rtl/rasmr_checker.sv =====
`default_nettype none
module rasmr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic full,
  input wire logic empty,
  input wire logic pop
);
  // result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty) else $error("result dropped");
  // no result and no full queue right after reset
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> (empty && !full))
    else $error("result or full after reset");
  // a popped word is not shown again on the next cycle
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop) |=> empty) else $error("result repeated");
endmodule

bind rational_add_sub_mul_reduce_core rasmr_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .full(full), .empty(empty), .pop(pop)
);
`default_nettype wire
